// File: design/akat_pkg.sv
`default_nettype none
package akat_pkg;
  localparam logic [1:0] KIND_AUTH  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLR   = 2'd2;
  localparam logic [1:0] KIND_CLRALL = 2'd3;

  localparam logic [2:0] REG_MGMT_KEY = 3'd0;
  localparam logic [2:0] REG_CFG_KEY  = 3'd1;
  localparam logic [2:0] REG_MAX_KEY  = 3'd2;
  localparam logic [2:0] REG_KEYS_EN  = 3'd3;
  localparam logic [2:0] REG_TO_EN    = 3'd4;
  localparam logic [2:0] REG_TO_TICKS = 3'd5;
  localparam logic [2:0] REG_EXT_TIME = 3'd6;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_MGMT = 2'd1;
  localparam logic [1:0] LVL_CFG  = 2'd2;
  localparam logic [1:0] LVL_MAX  = 2'd3;

  localparam int EntryW = 50;

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  lvl;
    logic [31:0] stamp;
  } entry_t;
endpackage
`default_nettype wire

// File: design/akat_ram.sv
`default_nettype none
module akat_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: design/access_key_authorization_table.sv
`default_nettype none
// Access level table for 16-bit device addresses, held in one synchronous RAM.
// start is taken only while busy is low; each item gives exactly one result,
// shown for one cycle with done_o high, and the receiver cannot stall it.
// A query or clear reads up to the fill count, one entry at a time (issue read,
// test); a clear of one address adds a shift pass over every later entry. A grant
// runs a compaction pass (read, test expiry, write back), a search pass and, on a
// full table, an oldest-stamp pass, each over the entries one by one.
// Clear all only resets the fill count. No clearing pass.
module access_key_authorization_table
  import akat_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] address_i,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] now_time_i,
  output logic             done_o,
  output logic [1:0]       level_o,
  output logic             denied_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CRD    = 4'd1;  // compaction: issue read
  localparam logic [3:0] S_CCHK   = 4'd2;  // compaction: test and write back
  localparam logic [3:0] S_SRD    = 4'd3;  // search: issue read
  localparam logic [3:0] S_SCHK   = 4'd4;
  localparam logic [3:0] S_ORD    = 4'd5;  // oldest search
  localparam logic [3:0] S_OCHK   = 4'd6;
  localparam logic [3:0] S_WR     = 4'd7;
  localparam logic [3:0] S_SHRD   = 4'd8;  // shift after clear address
  localparam logic [3:0] S_SHWR   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [31:0] mgmt_key_q, cfg_key_q, max_key_q, to_ticks_q;
  logic keys_en_q, to_en_q, ext_time_q;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   tick_q, tick_d;
  logic [CW-1:0] rd_q, rd_d;   // read pointer
  logic [CW-1:0] wr_q, wr_d;   // write pointer / found index
  logic [1:0]    kind_q, kind_d;
  logic [15:0]   addr_q, addr_d;
  logic [1:0]    lvl_q, lvl_d;
  logic          den_q, den_d;
  logic [31:0]   now_q, now_d;
  logic [31:0]   old_stamp_q, old_stamp_d;
  logic [CW-1:0] old_idx_q, old_idx_d;
  logic          done_q, done_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [EntryW-1:0] rdata_raw;

  akat_ram #(.Width(EntryW), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign level_o     = lvl_q;
  assign denied_o    = den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mgmt_key_q <= '1;
      cfg_key_q  <= '1;
      max_key_q  <= '1;
      keys_en_q  <= 1'b0;
      to_en_q    <= 1'b0;
      to_ticks_q <= '0;
      ext_time_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MGMT_KEY: mgmt_key_q <= cfg_data_i;
        REG_CFG_KEY:  cfg_key_q  <= cfg_data_i;
        REG_MAX_KEY:  max_key_q  <= cfg_data_i;
        REG_KEYS_EN:  keys_en_q  <= cfg_data_i[0];
        REG_TO_EN:    to_en_q    <= cfg_data_i[0];
        REG_TO_TICKS: to_ticks_q <= cfg_data_i;
        REG_EXT_TIME: ext_time_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic expired;
  assign expired = to_en_q && ((now_q - rdata.stamp) >= to_ticks_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    tick_d  = tick_q;
    rd_d    = rd_q;
    wr_d    = wr_q;
    kind_d  = kind_q;
    addr_d  = addr_q;
    lvl_d   = lvl_q;
    den_d   = den_q;
    now_d   = now_q;
    old_stamp_d = old_stamp_q;
    old_idx_d   = old_idx_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = wr_q[AW-1:0];
    wdata   = rdata;
    raddr   = rd_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d = kind_i;
          addr_d = address_i;
          lvl_d  = LVL_NONE;
          den_d  = 1'b0;
          now_d  = now_time_i;
          rd_d   = '0;
          wr_d   = '0;
          priority case (kind_i)
            KIND_AUTH: begin
              priority if (!keys_en_q || key_i == max_key_q) lvl_d = LVL_MAX;
              else if (key_i == cfg_key_q) lvl_d = LVL_CFG;
              else if (key_i == mgmt_key_q) lvl_d = LVL_MGMT;
              else den_d = 1'b1;
              if (key_i != max_key_q && key_i != cfg_key_q &&
                  key_i != mgmt_key_q && keys_en_q) begin
                state_d = S_DONE;
              end else begin
                if (!ext_time_q) begin
                  tick_d = tick_q + 32'd1;
                  now_d  = tick_q + 32'd1;
                end
                state_d = S_CRD;
              end
            end
            KIND_CLRALL: begin
              count_d = '0;
              state_d = S_DONE;
            end
            default: state_d = S_SRD;
          endcase
        end
      end
      // compaction: rd walks all entries, wr keeps the survivors
      S_CRD: begin
        if (rd_q == count_q) begin
          count_d = wr_q;
          rd_d    = '0;
          state_d = S_SRD;
        end else begin
          state_d = S_CCHK;
        end
      end
      S_CCHK: begin
        if (!expired) begin
          we   = 1'b1;
          wr_d = wr_q + CW'(1);
        end
        rd_d    = rd_q + CW'(1);
        raddr   = rd_d[AW-1:0];
        state_d = S_CRD;
      end
      S_SRD: begin
        if (rd_q == count_q) begin
          // not found
          priority case (kind_q)
            KIND_AUTH: begin
              if (count_q != DepthC) begin
                wr_d    = count_q;
                count_d = count_q + CW'(1);
                state_d = S_WR;
              end else begin
                rd_d      = '0;
                old_idx_d = '0;
                state_d   = S_ORD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end else begin
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (rdata.addr == addr_q) begin
          wr_d = rd_q;
          priority case (kind_q)
            KIND_AUTH: state_d = S_WR;
            KIND_QUERY: begin
              if (!ext_time_q) begin
                tick_d = tick_q + 32'd1;
                now_d  = tick_q + 32'd1;
              end
              state_d = S_OCHK;  // reuses rdata for expiry test below
              kind_d  = KIND_QUERY;
            end
            default: begin
              rd_d    = rd_q + CW'(1);
              state_d = S_SHRD;
            end
          endcase
        end else begin
          rd_d    = rd_q + CW'(1);
          raddr   = rd_d[AW-1:0];
          state_d = S_SRD;
        end
      end
      S_ORD: begin
        if (rd_q == count_q) begin
          wr_d    = old_idx_q;
          state_d = S_WR;
        end else begin
          state_d = S_OCHK;
        end
      end
      S_OCHK: begin
        if (kind_q == KIND_QUERY) begin
          // rdata still holds the found entry (raddr held)
          lvl_d   = expired ? LVL_NONE : rdata.lvl;
          state_d = S_DONE;
        end else begin
          if (rd_q == '0 || rdata.stamp < old_stamp_q) begin
            old_stamp_d = rdata.stamp;
            old_idx_d   = rd_q;
          end
          rd_d    = rd_q + CW'(1);
          raddr   = rd_d[AW-1:0];
          state_d = S_ORD;
        end
      end
      S_WR: begin
        we          = 1'b1;
        wdata.addr  = addr_q;
        wdata.lvl   = lvl_q;
        wdata.stamp = now_q;
        state_d     = S_DONE;
      end
      // remove at wr: copy rd entry to rd-1
      S_SHRD: begin
        if (rd_q == count_q) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        we      = 1'b1;
        wr_d    = rd_q;
        rd_d    = rd_q + CW'(1);
        raddr   = rd_d[AW-1:0];
        state_d = S_SHRD;
      end
      S_DONE: begin
        if (kind_q == KIND_CLR || kind_q == KIND_CLRALL) lvl_d = LVL_NONE;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // final level is valid in the cycle done_q is high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      tick_q  <= '0;
      done_q  <= 1'b0;
      lvl_q   <= LVL_NONE;
      den_q   <= 1'b0;
      kind_q  <= KIND_AUTH;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      tick_q  <= tick_d;
      done_q  <= done_d;
      lvl_q   <= lvl_d;
      den_q   <= den_d;
      kind_q  <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q        <= rd_d;
    wr_q        <= wr_d;
    addr_q      <= addr_d;
    now_q       <= now_d;
    old_stamp_q <= old_stamp_d;
    old_idx_q   <= old_idx_d;
  end
endmodule
`default_nettype wire

// File: test/access_key_authorization_table_checker.sv
`timescale 1ns / 100ps
module access_key_authorization_table_checker
  import akat_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] address_i,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] now_time_i,
  input  wire logic        done_o,
  input  wire logic [1:0]  level_o,
  input  wire logic        denied_o,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);

  typedef struct packed {
    logic [1:0] level;
    logic       denied;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [31:0] mgmt_key, cfg_key, max_key, timeout_ticks;
  logic        keys_on, timeout_on, ext_time;
  entry_t      table_q[TABLE_DEPTH];
  int          fill;
  logic [31:0] ticks;

  function automatic logic [31:0] take_time(input logic [31:0] now_in);
    if (ext_time) return now_in;
    ticks = ticks + 32'd1;
    return ticks;
  endfunction

  function automatic logic aged_out(input int idx, input logic [31:0] now);
    logic [31:0] age;
    age = now - table_q[idx].stamp;
    return timeout_on && (age >= timeout_ticks);
  endfunction

  function automatic int lookup(input logic [15:0] addr);
    for (int i = 0; i < fill; i++)
      if (table_q[i].addr == addr) return i;
    return -1;
  endfunction

  function automatic void drop(input int idx);
    for (int i = idx; i + 1 < fill; i++) table_q[i] = table_q[i + 1];
    fill--;
  endfunction

  function automatic void record_grant(input logic [15:0] addr, input logic [1:0] lvl,
                                       input logic [31:0] now_in);
    logic [31:0] now;
    int i;
    int hit;
    int oldest;
    now = take_time(now_in);
    i = 0;
    while (i < fill) begin
      if (aged_out(i, now)) drop(i);
      else i++;
    end
    hit = lookup(addr);
    if (hit >= 0) begin
      table_q[hit].lvl = lvl;
      table_q[hit].stamp = now;
    end else if (fill < TABLE_DEPTH) begin
      table_q[fill] = '{addr: addr, lvl: lvl, stamp: now};
      fill++;
    end else begin
      oldest = 0;
      for (int j = 1; j < fill; j++)
        if (table_q[j].stamp < table_q[oldest].stamp) oldest = j;
      table_q[oldest] = '{addr: addr, lvl: lvl, stamp: now};
    end
  endfunction

  function automatic verdict_t predict_access(input logic [1:0] kind, input logic [15:0] addr,
                                              input logic [31:0] key,
                                              input logic [31:0] now_in);
    verdict_t v;
    int hit;
    logic [31:0] now;
    v = '0;
    case (kind)
      KIND_AUTH: begin
        if (!keys_on || key == max_key) v.level = LVL_MAX;
        else if (key == cfg_key) v.level = LVL_CFG;
        else if (key == mgmt_key) v.level = LVL_MGMT;
        else v.denied = 1'b1;
        if (!v.denied) record_grant(addr, v.level, now_in);
      end
      KIND_QUERY: begin
        hit = lookup(addr);
        if (hit >= 0) begin
          now = take_time(now_in);
          v.level = aged_out(hit, now) ? LVL_NONE : table_q[hit].lvl;
        end
      end
      KIND_CLR: begin
        hit = lookup(addr);
        if (hit >= 0) drop(hit);
      end
      default: fill = 0;
    endcase
    return v;
  endfunction

  assign pending_count = verdict_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    int errs;
    if (!rst_ni) begin
      mgmt_key <= '1;
      cfg_key <= '1;
      max_key <= '1;
      keys_on <= 1'b0;
      timeout_on <= 1'b0;
      timeout_ticks <= '0;
      ext_time <= 1'b0;
      fill = 0;
      ticks = '0;
      verdict_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      errs = 0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MGMT_KEY: mgmt_key <= cfg_data_i;
          REG_CFG_KEY:  cfg_key <= cfg_data_i;
          REG_MAX_KEY:  max_key <= cfg_data_i;
          REG_KEYS_EN:  keys_on <= cfg_data_i[0];
          REG_TO_EN:    timeout_on <= cfg_data_i[0];
          REG_TO_TICKS: timeout_ticks <= cfg_data_i;
          REG_EXT_TIME: ext_time <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (done_o) begin
        result_count <= result_count + 1;
        if (verdict_q.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          want = verdict_q.pop_front();
          if (level_o !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, level_o);
            errs++;
          end
          if (denied_o !== want.denied) begin
            $error("denied: expected %0d, got %0d", want.denied, denied_o);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (start && !busy)
        verdict_q.push_back(predict_access(kind_i, address_i, key_i, now_time_i));
    end
  end

endmodule

// File: test/access_key_authorization_table_test.sv
`timescale 1ns / 100ps
module access_key_authorization_table_test;
  import akat_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind_i = KIND_AUTH;
  logic [15:0] address_i = '0;
  logic [31:0] key_i = '0;
  logic [31:0] now_time_i = '0;
  logic        done_o;
  logic [1:0]  level_o;
  logic        denied_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending_count, result_count;
  int          burst_left = 0;
  logic [31:0] key_pool[3];
  logic [15:0] addr_pool[12];
  logic [31:0] clock_now = '0;

  always #2 clk_i = ~clk_i;

  access_key_authorization_table DUT (.*);

  access_key_authorization_table_checker checker_u (.*);

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    // idle gap between register writes
    repeat (2) @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // one item per call; start stays high across back-to-back items in a burst
  task automatic issue(input logic [1:0] kind, input logic [15:0] addr,
                       input logic [31:0] key, input logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start <= 1'b1;
    kind_i <= kind;
    address_i <= addr;
    key_i <= key;
    now_time_i <= now;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    start <= 1'b0;
    burst_left = 0;
    drain();
  endtask

  task automatic random_item();
    logic [1:0]  kind;
    logic [31:0] key;
    logic [15:0] addr;
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) kind = KIND_AUTH;
    else if (r < 80) kind = KIND_QUERY;
    else if (r < 97) kind = KIND_CLR;
    else kind = KIND_CLRALL;
    addr = $urandom_range(0, 4) == 0 ? 16'($urandom) : addr_pool[$urandom_range(0, 11)];
    key = $urandom_range(0, 4) == 0 ? $urandom : key_pool[$urandom_range(0, 2)];
    // time mostly moves forward, sometimes jumps back or wraps
    if ($urandom_range(0, 9) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, 6);
    issue(kind, addr, key, clock_now);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: keys disabled, full-table eviction, extremes of the fields
    issue(KIND_QUERY, 16'h0000, '0, '0);
    issue(KIND_AUTH, 16'hFFFF, 32'h0, 32'hFFFF_FFFF);
    issue(KIND_AUTH, 16'h0000, 32'hFFFF_FFFF, 32'h0);
    for (int i = 1; i <= 8; i++) issue(KIND_AUTH, 16'(i * 16'h1111), 32'(i), 32'(i));
    issue(KIND_QUERY, 16'hFFFF, '0, '0);
    issue(KIND_QUERY, 16'h1234, '0, '0);
    issue(KIND_CLR, 16'h2222, '0, '0);
    issue(KIND_CLR, 16'h1234, '0, '0);
    issue(KIND_CLRALL, '0, '0, '0);
    issue(KIND_QUERY, 16'h3333, '0, '0);
    quiesce();

    write_reg(REG_MGMT_KEY, 32'h0000_0001);
    write_reg(REG_CFG_KEY, 32'h8000_0000);
    write_reg(REG_MAX_KEY, 32'hA5A5_5A5A);
    write_reg(REG_KEYS_EN, 32'h1);
    write_reg(REG_TO_EN, 32'h1);
    write_reg(REG_TO_TICKS, 32'd3);
    write_reg(3'd7, 32'hFFFF_FFFF);
    issue(KIND_AUTH, 16'h00AA, 32'hA5A5_5A5A, '0);
    issue(KIND_AUTH, 16'h00BB, 32'h8000_0000, '0);
    issue(KIND_AUTH, 16'h00CC, 32'h0000_0001, '0);
    issue(KIND_AUTH, 16'h00DD, 32'h1234_5678, '0);
    issue(KIND_QUERY, 16'h00AA, '0, '0);
    issue(KIND_QUERY, 16'h00CC, '0, '0);
    issue(KIND_AUTH, 16'h00EE, 32'h0000_0001, '0);
    quiesce();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin key_pool = '{32'h0, 32'hFFFF_FFFF, 32'h5555_AAAA}; end
        1: begin key_pool = '{$urandom, $urandom, $urandom}; end
        default: begin key_pool = '{$urandom, $urandom, 32'h0}; end
      endcase
      for (int i = 0; i < 12; i++) addr_pool[i] = 16'($urandom);
      write_reg(REG_MGMT_KEY, key_pool[0]);
      write_reg(REG_CFG_KEY, key_pool[1]);
      write_reg(REG_MAX_KEY, key_pool[2]);
      write_reg(REG_KEYS_EN, phase == 1 ? 32'h0 : 32'h1);
      write_reg(REG_TO_EN, 32'(phase % 2));
      write_reg(REG_TO_TICKS, phase == 3 ? 32'hFFFF_FFFF :
                              phase == 5 ? 32'h0 : 32'($urandom_range(2, 20)));
      write_reg(REG_EXT_TIME, 32'(phase >= 2 && phase != 4));
      for (int n = 0; n < 240; n++) random_item();
      quiesce();
    end

    $display("covered %0d results over directed and six random phases:", result_count);
    $display("keys on and off, timeouts, internal and external time, eviction, clears");
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
